@@ rtl/pcsr_pkg.sv @@
package pcsr_pkg;

	localparam int unsigned VECTOR_DEPTH_DEF = 1024;
	localparam int unsigned MAX_ROWS_DEF     = 65536;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_NZ    = 2'd1,
		OP_EMPTY = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic [1:0] REG_MATRIX_VALUE = 2'd0;
	localparam logic [1:0] REG_SCALE_MODE   = 2'd1;
	localparam logic [1:0] REG_ALPHA_GAIN   = 2'd2;
	localparam logic [1:0] REG_BETA_GAIN    = 2'd3;

	localparam logic signed [31:0] MATRIX_VALUE_RST = 32'sd65536;
	localparam logic signed [31:0] ALPHA_GAIN_RST   = 32'sd65536;
	localparam logic signed [31:0] BETA_GAIN_RST    = 32'sd0;

	typedef struct packed {
		op_t                opcode;
		logic [9:0]         column_index;
		logic signed [31:0] load_value;
		logic               last_in_row;
		logic signed [31:0] old_output;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] row_result;
		logic [15:0]        row_number;
		logic               saturated;
	} out_word_t;

	typedef struct packed {
		logic signed [31:0] matrix_value;
		logic               scale_mode;
		logic signed [31:0] alpha_gain;
		logic signed [31:0] beta_gain;
	} cfg_t;

	// row close handed from the accumulate stage to the scaling sequencer
	typedef struct packed {
		logic               start;
		logic signed [47:0] sum;
		logic signed [31:0] old;
		logic [15:0]        row;
	} fin_req_t;

	typedef enum logic [2:0] {
		FS_IDLE,
		FS_MUL_LO,
		FS_MUL_HI,
		FS_CLIP,
		FS_MUL_A,
		FS_MUL_B,
		FS_SUM,
		FS_OUT
	} fin_state_t;

endpackage

@@ rtl/pcsr_vmem.sv @@
module pcsr_vmem #(
	parameter int unsigned DEPTH = pcsr_pkg::VECTOR_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [31:0]              wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [31:0]              rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/pcsr_finish.sv @@
module pcsr_finish (
	input  logic                clk,
	input  logic                arst_n,
	input  pcsr_pkg::cfg_t      cfg,
	input  pcsr_pkg::fin_req_t  req,
	output logic                idle,
	output logic                result_valid,
	input  logic                result_ready,
	output pcsr_pkg::out_word_t result
);

	pcsr_pkg::fin_state_t state_q, state_d;

	logic signed [47:0] sum_q;
	logic signed [31:0] old_q;
	logic [15:0]        row_q;
	logic signed [64:0] pl_q;
	logic signed [47:0] ph_q;
	logic signed [63:0] pa_q;
	logic signed [63:0] pb_q;
	logic signed [31:0] x_q;
	logic               sat_q;
	logic               out_valid_q;
	pcsr_pkg::out_word_t out_q;

	logic signed [79:0] prod;
	logic signed [79:0] prod_sh;
	logic               prod_ovf;
	logic signed [31:0] prod_clip;
	logic signed [48:0] y;
	logic               y_ovf;
	logic signed [31:0] y_clip;
	logic               load_ok;

	// value*sum = value*hi*2^32 + value*lo, lo taken unsigned
	assign prod    = $signed({ph_q, 32'b0}) + $signed({{15{pl_q[64]}}, pl_q});
	assign prod_sh = prod >>> 16;
	assign prod_ovf = !((&prod_sh[79:31]) || !(|prod_sh[79:31]));
	assign prod_clip = prod_ovf ? (prod_sh[79] ? 32'sh8000_0000 : 32'sh7fff_ffff)
		: prod_sh[31:0];

	assign y = $signed({pa_q[63], pa_q[63:16]}) + $signed({pb_q[63], pb_q[63:16]});
	assign y_ovf = !((&y[48:31]) || !(|y[48:31]));
	assign y_clip = y_ovf ? (y[48] ? 32'sh8000_0000 : 32'sh7fff_ffff) : y[31:0];

	assign load_ok = !out_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcsr_pkg::FS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pcsr_pkg::FS_IDLE:   if (req.start) state_d = pcsr_pkg::FS_MUL_LO;
			pcsr_pkg::FS_MUL_LO: state_d = pcsr_pkg::FS_MUL_HI;
			pcsr_pkg::FS_MUL_HI: state_d = pcsr_pkg::FS_CLIP;
			pcsr_pkg::FS_CLIP:   state_d = cfg.scale_mode ? pcsr_pkg::FS_MUL_A
				: pcsr_pkg::FS_OUT;
			pcsr_pkg::FS_MUL_A:  state_d = pcsr_pkg::FS_MUL_B;
			pcsr_pkg::FS_MUL_B:  state_d = pcsr_pkg::FS_SUM;
			pcsr_pkg::FS_SUM:    state_d = pcsr_pkg::FS_OUT;
			pcsr_pkg::FS_OUT:    if (load_ok) state_d = pcsr_pkg::FS_IDLE;
			default:             state_d = pcsr_pkg::FS_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pcsr_pkg::FS_IDLE: begin
				if (req.start) begin
					sum_q <= req.sum;
					old_q <= req.old;
					row_q <= req.row;
				end
			end
			pcsr_pkg::FS_MUL_LO: begin
				pl_q <= 65'(cfg.matrix_value) * 65'($signed({1'b0, sum_q[31:0]}));
			end
			pcsr_pkg::FS_MUL_HI: begin
				ph_q <= 48'(cfg.matrix_value) * 48'($signed(sum_q[47:32]));
			end
			pcsr_pkg::FS_CLIP: begin
				x_q   <= prod_clip;
				sat_q <= prod_ovf;
			end
			pcsr_pkg::FS_MUL_A: pa_q <= 64'(cfg.alpha_gain) * 64'(x_q);
			pcsr_pkg::FS_MUL_B: pb_q <= 64'(cfg.beta_gain) * 64'(old_q);
			pcsr_pkg::FS_SUM: begin
				x_q   <= y_clip;
				sat_q <= sat_q | y_ovf;
			end
			pcsr_pkg::FS_OUT: begin
				if (load_ok) begin
					out_q.row_result <= x_q;
					out_q.row_number <= row_q;
					out_q.saturated  <= sat_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == pcsr_pkg::FS_OUT && load_ok) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign idle         = (state_q == pcsr_pkg::FS_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

@@ rtl/pattern_csr_spmv_row_engine_unit.sv @@
// Pattern-only CSR sparse matrix-vector row engine, Q16.16.
// Input channel (item_valid/item_ready/item): load words write the dense
// vector memory, nonzero words gather one vector entry and add it to the row
// accumulator, empty-row words close a row without a gather. Output channel
// (result_valid/result_ready/result) gives one word per closed row.
// Loads and nonzeros that do not close a row are taken one per cycle while
// the sequencer is idle; the gather is a registered synchronous read of the
// vector memory followed by the accumulate stage.
// A closing word stalls the input until the scaling sequencer is idle again;
// the sequencer has one 32x32 multiplier step per cycle (two partial
// products for value*sum, then alpha and beta products in scaled mode)
// and then loads the result into the output register.
// A result waits in the output register while the receiver stalls; rows
// keep accumulating, and the next row close waits in the sequencer until
// the output register frees up. Reset clears the accumulator, row counter
// and configuration to defaults. The vector memory has no reset and must be
// loaded before it is gathered. The user must write configuration through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
module pattern_csr_spmv_row_engine_unit #(
	parameter int unsigned VECTOR_DEPTH = pcsr_pkg::VECTOR_DEPTH_DEF,
	parameter int unsigned MAX_ROWS     = pcsr_pkg::MAX_ROWS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  pcsr_pkg::in_word_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output pcsr_pkg::out_word_t result,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	localparam int unsigned AW = $clog2(VECTOR_DEPTH);
	localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	pcsr_pkg::cfg_t     cfg_q;
	pcsr_pkg::fin_req_t req;

	logic               accept;
	logic               in_range;
	logic [AW+9:0]      col_ext;
	logic [AW-1:0]      vaddr;
	logic [31:0]        rdata;
	logic               fin_idle;

	logic               valid_s1;
	logic               nz_s1;
	logic               close_s1;
	logic               hit_s1;
	logic signed [31:0] old_s1;

	logic signed [47:0] acc_q;
	logic signed [47:0] gather;
	logic signed [48:0] sum_wide;
	logic signed [47:0] acc_next;
	logic [RW-1:0]      row_q;
	logic [RW+15:0]     row_ext;

	assign accept   = item_valid && item_ready;
	assign col_ext  = {{AW{1'b0}}, item.column_index};
	assign vaddr    = col_ext[AW-1:0];
	assign in_range = {7'b0, item.column_index} < 17'(VECTOR_DEPTH);

	pcsr_vmem #(
		.DEPTH (VECTOR_DEPTH)
	) u_vmem (
		.clk   (clk),
		.we    (accept && item.opcode == pcsr_pkg::OP_LOAD && in_range),
		.waddr (vaddr),
		.wdata (item.load_value),
		.re    (accept && item.opcode == pcsr_pkg::OP_NZ),
		.raddr (vaddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.matrix_value <= pcsr_pkg::MATRIX_VALUE_RST;
			cfg_q.scale_mode   <= 1'b0;
			cfg_q.alpha_gain   <= pcsr_pkg::ALPHA_GAIN_RST;
			cfg_q.beta_gain    <= pcsr_pkg::BETA_GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pcsr_pkg::REG_MATRIX_VALUE: cfg_q.matrix_value <= cfg_data;
				pcsr_pkg::REG_SCALE_MODE:   cfg_q.scale_mode   <= cfg_data[0];
				pcsr_pkg::REG_ALPHA_GAIN:   cfg_q.alpha_gain   <= cfg_data;
				pcsr_pkg::REG_BETA_GAIN:    cfg_q.beta_gain    <= cfg_data;
				default: ;
			endcase
		end
	end

	// gather stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			nz_s1    <= 1'b0;
			close_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && (item.opcode == pcsr_pkg::OP_NZ
				|| item.opcode == pcsr_pkg::OP_EMPTY);
			nz_s1    <= item.opcode == pcsr_pkg::OP_NZ;
			close_s1 <= item.opcode == pcsr_pkg::OP_EMPTY
				|| (item.opcode == pcsr_pkg::OP_NZ && item.last_in_row);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_s1 <= in_range;
			old_s1 <= item.old_output;
		end
	end

	// accumulate stage, saturating at 48 bits
	assign gather   = (nz_s1 && hit_s1) ? {{16{rdata[31]}}, rdata} : '0;
	assign sum_wide = {acc_q[47], acc_q} + {gather[47], gather};
	assign acc_next = (sum_wide[48] != sum_wide[47])
		? (sum_wide[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}}) : sum_wide[47:0];

	assign row_ext = {16'b0, row_q};

	assign req.start = valid_s1 && close_s1;
	assign req.sum   = acc_next;
	assign req.old   = old_s1;
	assign req.row   = row_ext[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			row_q <= '0;
		end else if (valid_s1) begin
			if (close_s1) begin
				acc_q <= '0;
				row_q <= (row_q == RW'(MAX_ROWS - 1)) ? '0 : row_q + RW'(1);
			end else begin
				acc_q <= acc_next;
			end
		end
	end

	assign item_ready = fin_idle && !(valid_s1 && close_s1);

	pcsr_finish u_finish (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.req          (req),
		.idle         (fin_idle),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> fin_idle)
		else $error("row close issued while scaling sequencer busy");

	a_close_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (item.opcode == pcsr_pkg::OP_EMPTY
		|| (item.opcode == pcsr_pkg::OP_NZ && item.last_in_row))) |=> !item_ready)
		else $error("input not stalled after row close");

	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> acc_q == '0)
		else $error("accumulator not cleared after row close");

endmodule

@@ sim/pattern_csr_spmv_row_engine_unit_tb.sv @@
`timescale 1ns / 100ps

module pattern_csr_spmv_row_engine_unit_tb;

	localparam int unsigned QUIET_LIMIT = 5000;

	class row_scoreboard;
		logic signed [31:0]  vec [pcsr_pkg::VECTOR_DEPTH_DEF];
		logic signed [47:0]  acc;
		logic [15:0]         row_count;
		pcsr_pkg::cfg_t      cfg;
		pcsr_pkg::out_word_t rows_due [$];
		int                  errors;

		function new();
			acc = '0;
			row_count = '0;
			cfg.matrix_value = pcsr_pkg::MATRIX_VALUE_RST;
			cfg.scale_mode = 1'b0;
			cfg.alpha_gain = pcsr_pkg::ALPHA_GAIN_RST;
			cfg.beta_gain = pcsr_pkg::BETA_GAIN_RST;
			errors = 0;
		endfunction

		function void clip32(input logic signed [79:0] v, output logic signed [31:0] c,
				output logic clipped);
			clipped = (v[79:31] != {49{v[79]}});
			if (clipped) begin
				c = v[79] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			end else begin
				c = v[31:0];
			end
		endfunction

		function void accept_word(pcsr_pkg::in_word_t w);
			logic signed [48:0]  s;
			logic signed [79:0]  p;
			logic signed [63:0]  pa, pb;
			logic signed [31:0]  x;
			logic                sx, sy;
			logic                close;
			pcsr_pkg::out_word_t r;
			close = 1'b0;
			case (w.opcode)
				pcsr_pkg::OP_LOAD: begin
					vec[w.column_index] = w.load_value;
				end
				pcsr_pkg::OP_NZ: begin
					s = 49'(acc) + 49'(vec[w.column_index]);
					if (s[48] != s[47]) begin
						acc = s[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
					end else begin
						acc = s[47:0];
					end
					close = w.last_in_row;
				end
				pcsr_pkg::OP_EMPTY: begin
					close = 1'b1;
				end
				default: ;
			endcase
			if (!close) return;
			p = 80'(cfg.matrix_value) * 80'(acc);
			clip32(p >>> 16, x, sx);
			sy = 1'b0;
			if (cfg.scale_mode) begin
				pa = 64'(cfg.alpha_gain) * 64'(x);
				pb = 64'(cfg.beta_gain) * 64'(w.old_output);
				p = 80'(pa >>> 16) + 80'(pb >>> 16);
				clip32(p, x, sy);
			end
			r.row_result = x;
			r.row_number = row_count;
			r.saturated = sx | sy;
			rows_due.push_back(r);
			acc = '0;
			row_count++;
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		task check_row(pcsr_pkg::out_word_t got);
			pcsr_pkg::out_word_t want;
			if (rows_due.size() == 0) begin
				report($sformatf("unexpected word row %0d value %h", got.row_number,
					got.row_result));
				return;
			end
			want = rows_due.pop_front();
			if (got.row_result !== want.row_result)
				report($sformatf("row %0d value %h, want %h", want.row_number,
					got.row_result, want.row_result));
			if (got.row_number !== want.row_number)
				report($sformatf("row number %0d, want %0d", got.row_number,
					want.row_number));
			if (got.saturated !== want.saturated)
				report($sformatf("row %0d saturated %b, want %b", want.row_number,
					got.saturated, want.saturated));
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                item_valid;
	logic                item_ready;
	pcsr_pkg::in_word_t  item;
	logic                result_valid;
	logic                result_ready = 1'b0;
	pcsr_pkg::out_word_t result;
	logic                cfg_we;
	logic [1:0]          cfg_index;
	logic [31:0]         cfg_data;

	row_scoreboard sb = new();

	int unsigned send_idle = 6;
	int unsigned recv_stall = 61;
	int          words_sent = 0;
	int unsigned quiet_cycles = 0;
	bit          loaded_map [pcsr_pkg::VECTOR_DEPTH_DEF];
	int          loaded_cols [$];

	pattern_csr_spmv_row_engine_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(negedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_stall);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) sb.check_row(result);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// signed Q16.16 value spread over the low span bits
	function automatic logic [31:0] rand_q(int unsigned span);
		logic signed [31:0] v;
		v = $urandom;
		v = v <<< (32 - span);
		return v >>> (32 - span);
	endfunction

	function automatic logic [31:0] rand_data();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return rand_q(32);
			4, 5: return rand_q(24);
			default: return rand_q(19);
		endcase
	endfunction

	function automatic pcsr_pkg::in_word_t rand_word(pcsr_pkg::op_t op);
		pcsr_pkg::in_word_t w;
		w.opcode = op;
		w.column_index = 10'($urandom_range(1023));
		w.load_value = rand_data();
		w.last_in_row = 1'($urandom_range(1));
		w.old_output = rand_data();
		return w;
	endfunction

	function automatic pcsr_pkg::in_word_t make_load(logic [9:0] col, logic [31:0] val);
		pcsr_pkg::in_word_t w;
		w = rand_word(pcsr_pkg::OP_LOAD);
		w.column_index = col;
		w.load_value = val;
		return w;
	endfunction

	function automatic pcsr_pkg::in_word_t make_nz(logic [9:0] col, logic last);
		pcsr_pkg::in_word_t w;
		w = rand_word(pcsr_pkg::OP_NZ);
		w.column_index = col;
		w.last_in_row = last;
		return w;
	endfunction

	function automatic logic [9:0] pick_col();
		return 10'(loaded_cols[$urandom_range(loaded_cols.size() - 1)]);
	endfunction

	function automatic pcsr_pkg::cfg_t make_cfg(logic [31:0] mv, logic mode,
			logic [31:0] a, logic [31:0] b);
		pcsr_pkg::cfg_t c;
		c.matrix_value = mv;
		c.scale_mode = mode;
		c.alpha_gain = a;
		c.beta_gain = b;
		return c;
	endfunction

	task send_word(pcsr_pkg::in_word_t w);
		while ($urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		do @(posedge clk); while (!item_ready);
		sb.accept_word(w);
		if (w.opcode == pcsr_pkg::OP_LOAD && !loaded_map[w.column_index]) begin
			loaded_map[w.column_index] = 1'b1;
			loaded_cols.push_back(int'(w.column_index));
		end
		words_sent++;
		@(negedge clk);
	endtask

	task apply_setting(pcsr_pkg::cfg_t c);
		cfg_we <= 1'b1;
		cfg_index <= pcsr_pkg::REG_MATRIX_VALUE;
		cfg_data <= c.matrix_value;
		@(negedge clk);
		cfg_index <= pcsr_pkg::REG_SCALE_MODE;
		cfg_data <= {31'b0, c.scale_mode};
		@(negedge clk);
		cfg_index <= pcsr_pkg::REG_ALPHA_GAIN;
		cfg_data <= c.alpha_gain;
		@(negedge clk);
		cfg_index <= pcsr_pkg::REG_BETA_GAIN;
		cfg_data <= c.beta_gain;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.cfg = c;
	endtask

	// non-closing nonzeros may still be in flight after the last row word
	task drain_rows();
		item_valid <= 1'b0;
		while (sb.rows_due.size() != 0) @(posedge clk);
		repeat (24) @(negedge clk);
	endtask

	task run_directed();
		send_word(make_load(10'd0, 32'h7FFF_FFFF));
		send_word(make_load(10'd1023, 32'h8000_0000));
		send_word(make_load(10'h155, 32'h0001_0000));
		send_word(make_load(10'h2AA, 32'hFFFF_0000));
		send_word(make_nz(10'd0, 1'b0));
		send_word(make_nz(10'd0, 1'b1));
		send_word(make_nz(10'd1023, 1'b1));
		send_word(make_nz(10'd1023, 1'b0));
		send_word(make_nz(10'd1023, 1'b1));
		send_word(rand_word(pcsr_pkg::OP_EMPTY));
		send_word(rand_word(pcsr_pkg::OP_NONE));
		// empty row closing a row that already has a partial sum
		send_word(make_nz(10'h155, 1'b0));
		send_word(rand_word(pcsr_pkg::OP_EMPTY));
		send_word(make_nz(10'h2AA, 1'b0));
		send_word(make_nz(10'h155, 1'b1));
		send_word(make_load(10'h155, rand_data()));
		send_word(make_nz(10'h155, 1'b1));
		send_word(make_nz(10'h2AA, 1'b1));
	endtask

	task run_random(int count);
		int target, pick, k;
		target = words_sent + count;
		while (words_sent < target) begin
			pick = $urandom_range(99);
			if (pick < 20) begin
				send_word(make_load(10'($urandom_range(1023)), rand_data()));
			end else if (pick < 75) begin
				k = $urandom_range(6, 1);
				for (int i = 1; i <= k; i++) send_word(make_nz(pick_col(), i == k));
			end else if (pick < 85) begin
				send_word(rand_word(pcsr_pkg::OP_EMPTY));
			end else if (pick < 92) begin
				k = $urandom_range(4, 1);
				repeat (k) send_word(make_nz(pick_col(), 1'b0));
				send_word(rand_word(pcsr_pkg::OP_EMPTY));
			end else begin
				send_word(rand_word(pcsr_pkg::OP_NONE));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		run_directed();
		run_random(150);
		drain_rows();
		apply_setting(make_cfg(32'h7FFF_FFFF, 1'b0, rand_q(20), rand_q(20)));
		run_random(150);
		drain_rows();
		apply_setting(make_cfg(rand_q(19), 1'b1, 32'h7FFF_FFFF, 32'h8000_0000));
		run_random(150);

		drain_rows();
		send_idle = 61;
		recv_stall = 6;
		apply_setting(make_cfg(32'h8000_0000, 1'b1, rand_q(20), rand_q(20)));
		run_random(150);
		drain_rows();
		apply_setting(make_cfg(32'h0, 1'b0, rand_q(32), rand_q(32)));
		run_random(100);
		drain_rows();
		apply_setting(make_cfg(32'h0001_0000, 1'b1, 32'h0, 32'h0001_0000));
		run_random(100);

		drain_rows();
		send_idle = 0;
		recv_stall = 0;
		apply_setting(make_cfg(rand_q(20), 1'b0, rand_q(20), rand_q(20)));
		run_random(100);
		drain_rows();
		apply_setting(make_cfg(rand_q(18), 1'b1, rand_q(18), rand_q(18)));
		run_random(150);

		drain_rows();
		repeat (6) @(posedge clk);
		if (sb.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
